@@ design/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
package deq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [2:0] OP_SIZE       = 3'd6;
    localparam logic [2:0] OP_CLEAR      = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;    // capture the input beat
        logic exec;     // apply the request to pointers and memory
        logic load;     // move the result into the output registers
    } deq_cmd_t;

endpackage

@@ design/deq_ctrl.sv @@
// Request sequencer and output handshake control for the double-ended queue.
module deq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output deq_pkg::deq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd.latch = (state_reg == S_IDLE) && in_valid;
        cmd.exec  = (state_reg == S_EXEC);
        // result may enter the output slot once it is empty or being drained
        cmd.load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.latch)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (cmd.load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ design/deq_dp.sv @@
// Datapath of the double-ended queue: storage, head and count, result registers.
module deq_dp
#(
    parameter int DEPTH = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  deq_pkg::deq_cmd_t                cmd,
    input  logic [2:0]                       op,
    input  logic signed [31:0]               value,
    output logic [1:0]                       status,
    output logic signed [31:0]               data,
    output logic [$clog2(DEPTH + 1) - 1:0]   count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   mem_q_reg;

    logic [2:0]    op_reg;
    logic [31:0]   val_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [1:0]    res_status_reg;
    logic [1:0]    res_status_next;
    logic          res_rd_reg;
    logic          res_rd_next;

    logic [1:0]    status_reg;
    logic [31:0]   data_reg;
    logic [CW-1:0] count_reg;

    logic          full;
    logic          empty;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] tail_pos;
    logic [AW-1:0] last_pos;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    always_comb
    begin
        full     = (occ_reg == CW'(DEPTH));
        empty    = (occ_reg == '0);
        head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

        // sums stay below twice the depth: one conditional subtract wraps them
        tail_sum = SW'(head_reg) + SW'(occ_reg);
        last_sum = tail_sum - SW'(1);
        if (tail_sum >= SW'(DEPTH))
            tail_pos = AW'(tail_sum - SW'(DEPTH));
        else
            tail_pos = AW'(tail_sum);
        if (last_sum >= SW'(DEPTH))
            last_pos = AW'(last_sum - SW'(DEPTH));
        else
            last_pos = AW'(last_sum);

        mem_we          = 1'b0;
        mem_waddr       = tail_pos;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        res_status_next = deq_pkg::ST_OK;
        res_rd_next     = 1'b0;

        case (op_reg)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                    res_status_next = deq_pkg::ST_FULL;
                else
                begin
                    head_next = head_dec;
                    mem_waddr = head_dec;
                    mem_we    = 1'b1;
                    occ_next  = occ_reg + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                    res_status_next = deq_pkg::ST_FULL;
                else
                begin
                    mem_waddr = tail_pos;
                    mem_we    = 1'b1;
                    occ_next  = occ_reg + CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT:
            begin
                if (empty)
                    res_status_next = deq_pkg::ST_EMPTY;
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = head_reg;
                    res_rd_next = 1'b1;
                    if (op_reg == deq_pkg::OP_POP_FRONT)
                    begin
                        head_next = head_inc;
                        occ_next  = occ_reg - CW'(1);
                    end
                end
            end
            deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK:
            begin
                if (empty)
                    res_status_next = deq_pkg::ST_EMPTY;
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = last_pos;
                    res_rd_next = 1'b1;
                    if (op_reg == deq_pkg::OP_POP_BACK)
                        occ_next = occ_reg - CW'(1);
                end
            end
            deq_pkg::OP_SIZE:
            begin
                res_status_next = deq_pkg::ST_OK;
            end
            deq_pkg::OP_CLEAR:
            begin
                head_next = '0;
                occ_next  = '0;
            end
            default:
            begin
                res_status_next = deq_pkg::ST_OK;
            end
        endcase
    end

    // storage: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
            mem[mem_waddr] <= val_reg;
        if (cmd.exec && mem_re)
            mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= op;
            val_reg <= value;
        end
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_rd_reg     <= res_rd_next;
        end
        if (cmd.load)
        begin
            status_reg <= res_status_reg;
            data_reg   <= res_rd_reg ? mem_q_reg : 32'd0;
            count_reg  <= occ_reg;
        end
    end

    assign status = status_reg;
    assign data   = data_reg;
    assign count  = count_reg;

endmodule

@@ design/double_ended_queue_top.sv @@
// Top level of the double-ended queue block.
//
// Usage: one request beat on the input channel (op, value) yields exactly
// one result beat on the output channel (status, data, count).
// A beat moves on a rising edge where valid is high and stall is low.
// Requests: push front/back, pop front/back, peek front/back, size, clear.
// Pops and peeks on an empty queue return status empty; pushes on a full
// queue return status full. Refused requests leave the queue untouched.
// Steps: a request is captured, then in the execute state it does the pointer
// update and the single memory access, then in the done state the result moves
// into the output registers; only then is a new request taken.
// The output register decouples the sides: the next request is accepted
// and executed while an earlier result still waits under out_stall; only
// the transfer into the output register waits until that beat is taken.
// Reset clears the head pointer, the count and all valid flags; the
// storage itself is not cleared and needs no sweep.
module double_ended_queue_top
#(
    parameter int DEPTH = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     op,
    input  logic signed [31:0]             value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic signed [31:0]             data,
    output logic [$clog2(DEPTH + 1) - 1:0] count
);

    deq_pkg::deq_cmd_t cmd;

    // controller: sequencing and handshakes
    deq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: circular buffer, head/count, result registers
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op     (op),
        .value  (value),
        .status (status),
        .data   (data),
        .count  (count)
    );

endmodule
